/* hdl/coo_spmv_pkg.sv */
// ----------------------------------------------------------------------------
// coo_spmv_pkg: shared types and constants of the sparse matrix-vector block
// Request codes, field widths, default sizes and the controller/datapath link.
// ----------------------------------------------------------------------------
package coo_spmv_pkg;

	localparam int REQ_W  = 2;
	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;

	localparam int DEF_MAX_ROWS = 1024;
	localparam int DEF_MAX_COLS = 1024;

	typedef logic [REQ_W-1:0]  req_code_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [DATA_W-1:0] word_t;

	localparam req_code_t REQ_LOAD  = 2'd0;
	localparam req_code_t REQ_ACCUM = 2'd1;
	localparam req_code_t REQ_READ  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic latch;    // capture the accepted item
		logic clr_step; // zero one row sum of the clearing pass
		logic fetch;    // read both memories
		logic load_wr;  // write the vector element
		logic mul;      // register the product
		logic add_wr;   // write back the updated row sum
		logic rd_out;   // load the result register and clear the row
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		req_code_t req;
		logic      accum_ok; // nonzero value, row and column in range
		logic      clr_last; // last row of the clearing pass
		logic      out_free; // result register can take a new item
	} sts_t;

endpackage

/* hdl/coo_spmv_if.sv */
// ----------------------------------------------------------------------------
// coo_spmv_if: request and result channels
// Valid/ready channels carrying one request item or one result item.
// ----------------------------------------------------------------------------
interface coo_spmv_req_if;
	import coo_spmv_pkg::*;

	logic      valid;
	logic      ready;
	req_code_t req_type;
	idx_t      row_index;
	idx_t      col_index;
	word_t     data_value;

	modport source (output valid, req_type, row_index, col_index, data_value, input ready);
	modport sink   (input valid, req_type, row_index, col_index, data_value, output ready);
endinterface

interface coo_spmv_rsp_if;
	import coo_spmv_pkg::*;

	logic  valid;
	logic  ready;
	idx_t  out_row;
	word_t row_sum;

	modport source (output valid, out_row, row_sum, input ready);
	modport sink   (input valid, out_row, row_sum, output ready);
endinterface

/* hdl/coo_spmv_ram.sv */
// ----------------------------------------------------------------------------
// coo_spmv_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module coo_spmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/coo_spmv_dp.sv */
// ----------------------------------------------------------------------------
// coo_spmv_dp: datapath
// Item registers, vector and row-sum memories, multiplier, adder, result register.
// ----------------------------------------------------------------------------
module coo_spmv_dp #(
	parameter int MAX_ROWS = coo_spmv_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = coo_spmv_pkg::DEF_MAX_COLS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  coo_spmv_pkg::cmd_t        cmd,
	output coo_spmv_pkg::sts_t        sts,
	input  coo_spmv_pkg::req_code_t   req_type,
	input  coo_spmv_pkg::idx_t        row_index,
	input  coo_spmv_pkg::idx_t        col_index,
	input  coo_spmv_pkg::word_t       data_value,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output coo_spmv_pkg::idx_t        out_row,
	output coo_spmv_pkg::word_t       row_sum
);
	import coo_spmv_pkg::*;

	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam logic [RAW-1:0] CLR_LAST = RAW'(MAX_ROWS - 1);

	req_code_t req_q;
	idx_t      row_q;
	idx_t      col_q;
	word_t     val_q;
	word_t     prod_q;
	logic [RAW-1:0] clr_q;
	logic      out_valid_q;
	idx_t      out_row_q;
	word_t     out_sum_q;

	logic      row_ok;
	logic      col_ok;
	word_t     vec_rd;
	word_t     sum_rd;
	logic      row_we;
	logic [RAW-1:0] row_waddr;
	word_t     row_wdata;

	assign row_ok = 32'(row_q) < MAX_ROWS;
	assign col_ok = 32'(col_q) < MAX_COLS;

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			row_q <= row_index;
			col_q <= col_index;
			val_q <= data_value;
		end
		if (cmd.mul) begin
			prod_q <= val_q * vec_rd;
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + RAW'(1);
		end
	end

	coo_spmv_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_COLS)
	) u_vec_ram (
		.clk   (clk),
		.we    (cmd.load_wr && col_ok),
		.waddr (CAW'(col_q)),
		.wdata (val_q),
		.re    (cmd.fetch),
		.raddr (CAW'(col_q)),
		.rdata (vec_rd)
	);

	// single write port shared by clearing, accumulate and read-clear
	always_comb begin
		row_we    = 1'b0;
		row_waddr = RAW'(row_q);
		row_wdata = '0;
		if (cmd.clr_step) begin
			row_we    = 1'b1;
			row_waddr = clr_q;
		end else if (cmd.add_wr) begin
			row_we    = 1'b1;
			row_wdata = sum_rd + prod_q;
		end else if (cmd.rd_out) begin
			row_we    = row_ok;
		end
	end

	coo_spmv_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ROWS)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (cmd.fetch),
		.raddr (RAW'(row_q)),
		.rdata (sum_rd)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_out) begin
			out_row_q <= row_q;
			out_sum_q <= row_ok ? sum_rd : '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign row_sum   = out_sum_q;

	assign sts.req      = req_q;
	assign sts.accum_ok = (val_q != '0) && row_ok && col_ok;
	assign sts.clr_last = (clr_q == CLR_LAST);
	assign sts.out_free = !out_valid_q || rsp_ready;

endmodule

/* hdl/coo_spmv_ctrl.sv */
// ----------------------------------------------------------------------------
// coo_spmv_ctrl: controller
// Sequences the clearing pass and the steps of one request item at a time.
// ----------------------------------------------------------------------------
module coo_spmv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output coo_spmv_pkg::cmd_t cmd,
	input  coo_spmv_pkg::sts_t sts
);
	import coo_spmv_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.latch    = req_valid && req_ready;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				case (sts.req)
					REQ_LOAD: begin
						cmd.load_wr = 1'b1;
						state_d     = ST_IDLE;
					end
					REQ_ACCUM: state_d = sts.accum_ok ? ST_DATA : ST_IDLE;
					REQ_READ:  state_d = ST_DATA;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_DATA: begin
				if (sts.req == REQ_ACCUM) begin
					cmd.mul = 1'b1;
					state_d = ST_ADD;
				end else if (sts.out_free) begin
					cmd.rd_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_ADD: begin
				cmd.add_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/coo_sparse_matvec.sv */
// ----------------------------------------------------------------------------
// coo_sparse_matvec: sparse matrix (coordinate form) times dense vector
// steps: load IDLE, FETCH; read IDLE, FETCH, DATA (waits there for a free
//   result register, then registers the result); accumulate (nonzero, in
//   range) IDLE, FETCH, DATA, ADD for the row-sum read-modify-write; others IDLE, FETCH
// reset: clearing pass zeroes all MAX_ROWS row sums, ready stays low
// ----------------------------------------------------------------------------
module coo_sparse_matvec #(
	parameter int MAX_ROWS = coo_spmv_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = coo_spmv_pkg::DEF_MAX_COLS
) (
	input  logic            clk,
	input  logic            arst_n,
	coo_spmv_req_if.sink    req,
	coo_spmv_rsp_if.source  rsp
);
	import coo_spmv_pkg::*;

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	// controller: one item at a time, clearing pass after reset
	coo_spmv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: vector memory, row-sum memory, multiply-add, result register
	coo_spmv_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req.req_type),
		.row_index  (req.row_index),
		.col_index  (req.col_index),
		.data_value (req.data_value),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.out_row    (rsp.out_row),
		.row_sum    (rsp.row_sum)
	);

`ifndef SYNTHESIS
	// no item is taken while the row sums are being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !req.ready)
		else $error("item accepted during clearing pass");

	// a pending result is never overwritten
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_out |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten");

	// one item at a time: no acceptance in the cycle after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item accepted while another is in work");

	// result valid rises only after a read item's last step
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.rd_out))
		else $error("result without read item");
`endif

endmodule
